// ----- src/clle_pkg.sv -----
// Shared constants, codes and types for the cursor linked list engine.
`timescale 1ns / 1ps

package clle_pkg;

   // Node pool geometry
   localparam int CAPACITY   = 256;
   localparam int NODE_BITS  = $clog2(CAPACITY);
   localparam int COUNT_BITS = NODE_BITS + 1;
   localparam int VALUE_BITS = 32;
   localparam int OP_BITS    = 3;
   localparam int STAT_BITS  = 2;

   // Operation codes carried on the request tuser
   localparam logic [OP_BITS-1:0] OP_RIGHT      = 3'd0;
   localparam logic [OP_BITS-1:0] OP_LEFT       = 3'd1;
   localparam logic [OP_BITS-1:0] OP_INS_AFTER  = 3'd2;
   localparam logic [OP_BITS-1:0] OP_INS_BEFORE = 3'd3;
   localparam logic [OP_BITS-1:0] OP_DELETE     = 3'd4;

   // Result status codes
   localparam logic [STAT_BITS-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STAT_BITS-1:0] STATUS_BOUNDARY = 2'd1;
   localparam logic [STAT_BITS-1:0] STATUS_FULL     = 2'd2;

   // Resolved action for one item, chosen from the opcode and the list shape
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_BOUNDARY,
      ACT_FULL,
      ACT_RIGHT,
      ACT_LEFT,
      ACT_INS_FIRST,
      ACT_INS_AFTER_MID,
      ACT_INS_AFTER_TAIL,
      ACT_INS_BEFORE_HEAD,
      ACT_INS_BEFORE_MID,
      ACT_DEL_ONLY,
      ACT_DEL_HEAD,
      ACT_DEL_TAIL,
      ACT_DEL_MID
   } act_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LINK,
      ST_FETCH,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic    accept;
      logic    update;
      logic    link;
      logic    fetch;
      logic    load;
      act_type act;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic count_zero;
      logic count_one;
      logic at_head;
      logic at_tail;
      logic pool_full;
      logic out_busy;
   } stat_type;

endpackage

// ----- src/clle_ctrl.sv -----
// Controller state machine: sequences one list operation through the datapath.
`timescale 1ns / 1ps

module clle_ctrl
   import clle_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [OP_BITS-1:0] op,
   input  stat_type           stat,
   output cmd_type            cmd
);

   state_type          state_ff, state_in;
   act_type            act_ff, act_in;
   logic [OP_BITS-1:0] op_ff, op_in;
   act_type            act_dec;

   // Resolve the opcode against the current list shape
   always_comb begin
      act_dec = ACT_NONE;
      unique case (op_ff)
         OP_RIGHT: begin
            act_dec = (stat.count_zero || stat.at_tail) ? ACT_BOUNDARY : ACT_RIGHT;
         end
         OP_LEFT: begin
            act_dec = (stat.count_zero || stat.at_head) ? ACT_BOUNDARY : ACT_LEFT;
         end
         OP_INS_AFTER: begin
            priority if (stat.pool_full)  act_dec = ACT_FULL;
            else if (stat.count_zero)     act_dec = ACT_INS_FIRST;
            else if (stat.at_tail)        act_dec = ACT_INS_AFTER_TAIL;
            else                          act_dec = ACT_INS_AFTER_MID;
         end
         OP_INS_BEFORE: begin
            priority if (stat.pool_full)  act_dec = ACT_FULL;
            else if (stat.count_zero)     act_dec = ACT_INS_FIRST;
            else if (stat.at_head)        act_dec = ACT_INS_BEFORE_HEAD;
            else                          act_dec = ACT_INS_BEFORE_MID;
         end
         OP_DELETE: begin
            priority if (stat.count_zero) act_dec = ACT_NONE;
            else if (stat.count_one)      act_dec = ACT_DEL_ONLY;
            else if (stat.at_head)        act_dec = ACT_DEL_HEAD;
            else if (stat.at_tail)        act_dec = ACT_DEL_TAIL;
            else                          act_dec = ACT_DEL_MID;
         end
         default: act_dec = ACT_NONE;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_LINK;
         ST_LINK:   state_in = ST_FETCH;
         ST_FETCH:  state_in = ST_DONE;
         ST_DONE:   if (!stat.out_busy) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      cmd.act    = act_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            cmd.act    = act_dec;
         end
         ST_LINK:  cmd.link  = 1'b1;
         ST_FETCH: cmd.fetch = 1'b1;
         ST_DONE:  cmd.load  = !stat.out_busy;
         default: ;
      endcase
   end

   // Latched opcode and resolved action
   always_comb begin
      op_in  = op_ff;
      act_in = act_ff;
      if (cmd.accept) op_in = op;
      if (cmd.update) act_in = act_dec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         act_ff   <= ACT_NONE;
      end else begin
         state_ff <= state_in;
         act_ff   <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

endmodule

// ----- src/clle_datapath.sv -----
// Datapath: node memories, list registers, free chain and result register.
`timescale 1ns / 1ps

module clle_datapath
   import clle_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic [VALUE_BITS-1:0] value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STAT_BITS-1:0]  rsp_status,
   output logic [VALUE_BITS-1:0] rsp_value,
   output logic [NODE_BITS-1:0]  rsp_position,
   output logic [COUNT_BITS-1:0] rsp_length,
   output logic                  rsp_empty
);

   // Node stores
   logic [VALUE_BITS-1:0] val_mem [CAPACITY];
   logic [NODE_BITS-1:0]  fwd_mem [CAPACITY];
   logic [NODE_BITS-1:0]  bwd_mem [CAPACITY];

   // List state
   logic [NODE_BITS-1:0]  head_ff, head_in;
   logic [NODE_BITS-1:0]  cur_ff, cur_in;
   logic [NODE_BITS-1:0]  idx_ff, idx_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [NODE_BITS-1:0]  free_ff, free_in;
   logic [COUNT_BITS-1:0] mark_ff, mark_in;

   // Item payload and scratch
   logic [VALUE_BITS-1:0] word_ff, word_in;
   logic [NODE_BITS-1:0]  knode_ff, knode_in;

   // Registered memory reads
   logic [NODE_BITS-1:0]  nxt_ff;    // fwd link of the cursor
   logic [NODE_BITS-1:0]  fnext_ff;  // fwd link of the free chain head
   logic [NODE_BITS-1:0]  prv_ff;    // bwd link of the cursor
   logic [VALUE_BITS-1:0] rval_ff;

   // Result register
   logic                  ovalid_ff, ovalid_in;
   logic [STAT_BITS-1:0]  ostat_ff, ostat_in;
   logic [VALUE_BITS-1:0] oval_ff, oval_in;
   logic [NODE_BITS-1:0]  opos_ff, opos_in;
   logic [COUNT_BITS-1:0] olen_ff, olen_in;
   logic                  oempty_ff, oempty_in;

   // Write ports
   logic                  fwd_we, bwd_we, val_we;
   logic [NODE_BITS-1:0]  fwd_wa, fwd_wd, bwd_wa, bwd_wd;

   logic                  chain_ready;
   logic [NODE_BITS-1:0]  knode_new;
   logic                  is_insert, is_delete;
   logic [COUNT_BITS-1:0] idx_next;

   // List shape flags
   always_comb begin
      idx_next        = {1'b0, idx_ff} + COUNT_BITS'(1);
      stat.count_zero = (count_ff == '0);
      stat.count_one  = (count_ff == COUNT_BITS'(1));
      stat.at_head    = (idx_ff == '0);
      stat.at_tail    = (idx_next >= count_ff);
      stat.pool_full  = (count_ff >= COUNT_BITS'(CAPACITY));
      stat.out_busy   = ovalid_ff && !rsp_ready;
   end

   // Node allocation: freed chain first, then the untouched region
   always_comb begin
      chain_ready = (mark_ff > count_ff);
      knode_new   = chain_ready ? free_ff : mark_ff[NODE_BITS-1:0];
      is_insert   = (cmd.act == ACT_INS_FIRST) || (cmd.act == ACT_INS_AFTER_MID) ||
                    (cmd.act == ACT_INS_AFTER_TAIL) || (cmd.act == ACT_INS_BEFORE_HEAD) ||
                    (cmd.act == ACT_INS_BEFORE_MID);
      is_delete   = (cmd.act == ACT_DEL_ONLY) || (cmd.act == ACT_DEL_HEAD) ||
                    (cmd.act == ACT_DEL_TAIL) || (cmd.act == ACT_DEL_MID);
   end

   // Link writes: first half in update, second half in link
   always_comb begin
      fwd_we = 1'b0;
      fwd_wa = '0;
      fwd_wd = '0;
      bwd_we = 1'b0;
      bwd_wa = '0;
      bwd_wd = '0;
      val_we = cmd.update && is_insert;
      if (cmd.update) begin
         unique case (cmd.act)
            ACT_INS_AFTER_MID: begin
               fwd_we = 1'b1; fwd_wa = knode_new; fwd_wd = nxt_ff;
               bwd_we = 1'b1; bwd_wa = nxt_ff;    bwd_wd = knode_new;
            end
            ACT_INS_BEFORE_MID: begin
               fwd_we = 1'b1; fwd_wa = prv_ff;    fwd_wd = knode_new;
               bwd_we = 1'b1; bwd_wa = knode_new; bwd_wd = prv_ff;
            end
            ACT_DEL_MID: begin
               fwd_we = 1'b1; fwd_wa = prv_ff; fwd_wd = nxt_ff;
               bwd_we = 1'b1; bwd_wa = nxt_ff; bwd_wd = prv_ff;
            end
            default: ;
         endcase
      end
      if (cmd.link) begin
         unique case (cmd.act)
            ACT_INS_AFTER_MID, ACT_INS_AFTER_TAIL: begin
               fwd_we = 1'b1; fwd_wa = cur_ff;   fwd_wd = knode_ff;
               bwd_we = 1'b1; bwd_wa = knode_ff; bwd_wd = cur_ff;
            end
            ACT_INS_BEFORE_HEAD, ACT_INS_BEFORE_MID: begin
               fwd_we = 1'b1; fwd_wa = knode_ff; fwd_wd = cur_ff;
               bwd_we = 1'b1; bwd_wa = cur_ff;   bwd_wd = knode_ff;
            end
            ACT_DEL_ONLY, ACT_DEL_HEAD, ACT_DEL_TAIL, ACT_DEL_MID: begin
               // freed node goes on top of the free chain
               fwd_we = 1'b1; fwd_wa = cur_ff; fwd_wd = free_ff;
            end
            default: ;
         endcase
      end
   end

   // Register next values
   always_comb begin
      head_in  = head_ff;
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      free_in  = free_ff;
      mark_in  = mark_ff;
      word_in  = word_ff;
      knode_in = knode_ff;

      if (cmd.accept) word_in = value;

      if (cmd.update && is_insert) begin
         knode_in = knode_new;
         if (chain_ready) free_in = fnext_ff;
         else             mark_in = mark_ff + COUNT_BITS'(1);
      end

      if (cmd.link) begin
         if (is_insert) begin
            cur_in   = knode_ff;
            count_in = count_ff + COUNT_BITS'(1);
         end
         if (is_delete) begin
            count_in = count_ff - COUNT_BITS'(1);
            free_in  = cur_ff;
         end
         unique case (cmd.act)
            ACT_RIGHT: begin
               cur_in = nxt_ff;
               idx_in = idx_ff + NODE_BITS'(1);
            end
            ACT_LEFT: begin
               cur_in = prv_ff;
               idx_in = idx_ff - NODE_BITS'(1);
            end
            ACT_INS_FIRST: begin
               head_in = knode_ff;
               idx_in  = '0;
            end
            ACT_INS_AFTER_MID, ACT_INS_AFTER_TAIL: idx_in = idx_ff + NODE_BITS'(1);
            ACT_INS_BEFORE_HEAD: head_in = knode_ff;
            ACT_DEL_ONLY: begin
               head_in = '0;
               cur_in  = '0;
               idx_in  = '0;
            end
            ACT_DEL_HEAD: begin
               head_in = nxt_ff;
               cur_in  = nxt_ff;
            end
            ACT_DEL_TAIL: begin
               cur_in = prv_ff;
               idx_in = idx_ff - NODE_BITS'(1);
            end
            ACT_DEL_MID: cur_in = nxt_ff;
            default: ;
         endcase
      end
   end

   // Result register
   always_comb begin
      ovalid_in = ovalid_ff;
      ostat_in  = ostat_ff;
      oval_in   = oval_ff;
      opos_in   = opos_ff;
      olen_in   = olen_ff;
      oempty_in = oempty_ff;
      if (cmd.load) begin
         ovalid_in = 1'b1;
         unique case (cmd.act)
            ACT_BOUNDARY: ostat_in = STATUS_BOUNDARY;
            ACT_FULL:     ostat_in = STATUS_FULL;
            default:      ostat_in = STATUS_DONE;
         endcase
         oval_in   = stat.count_zero ? '0 : rval_ff;
         opos_in   = stat.count_zero ? '0 : idx_ff;
         olen_in   = count_ff;
         oempty_in = stat.count_zero;
      end else if (rsp_ready) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         cur_ff    <= '0;
         idx_ff    <= '0;
         count_ff  <= '0;
         free_ff   <= '0;
         mark_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         cur_ff    <= cur_in;
         idx_ff    <= idx_in;
         count_ff  <= count_in;
         free_ff   <= free_in;
         mark_ff   <= mark_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      knode_ff  <= knode_in;
      ostat_ff  <= ostat_in;
      oval_ff   <= oval_in;
      opos_ff   <= opos_in;
      olen_ff   <= olen_in;
      oempty_ff <= oempty_in;
   end

   // Node memories: one write port each, links read when an item is taken
   always_ff @(posedge clock) begin
      if (val_we) val_mem[knode_new] <= word_ff;
      if (cmd.fetch) rval_ff <= val_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
      if (cmd.accept) begin
         nxt_ff   <= fwd_mem[cur_ff];
         fnext_ff <= fwd_mem[free_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (bwd_we) bwd_mem[bwd_wa] <= bwd_wd;
      if (cmd.accept) prv_ff <= bwd_mem[cur_ff];
   end

   assign rsp_valid    = ovalid_ff;
   assign rsp_status   = ostat_ff;
   assign rsp_value    = oval_ff;
   assign rsp_position = opos_ff;
   assign rsp_length   = olen_ff;
   assign rsp_empty    = oempty_ff;

endmodule

// ----- src/cursor_linked_list_engine.sv -----
// Top level of the cursor linked list engine: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Keeps an ordered list of 32-bit words with a cursor in a pool of 256 nodes,
// each with a value, a forward link and a backward link. One request item is
// one operation (step right/left, insert after/before, delete); every request
// gives exactly one response item with the status and a snapshot of cursor
// value, cursor position and length. From acceptance to a loaded response an
// item goes through the link read of the cursor node, the link writes in the
// update and link states through the single write port of each link memory,
// and the value read of the new cursor node. A new request is taken only in
// the idle state, after the last item's response is loaded. The response sits
// in an output register, so a new request is taken while an earlier response
// still waits; that request then holds before its load until the register
// frees. The list is empty after reset; no clearing pass is needed.

module cursor_linked_list_engine
   import clle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] value
   input  logic [2:0]  req_tuser,  // [2:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // [31:0] cursor_value, [39:32] cursor_position,
                                   // [48:40] length, [49] list_empty, [55:50] zero
   output logic [1:0]  rsp_tuser   // [1:0] status
);

   cmd_type               cmd;
   stat_type              stat;
   logic [VALUE_BITS-1:0] rsp_value;
   logic [NODE_BITS-1:0]  rsp_position;
   logic [COUNT_BITS-1:0] rsp_length;
   logic                  rsp_empty;

   clle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .op         (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   clle_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .value        (req_tdata),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_status   (rsp_tuser),
      .rsp_value    (rsp_value),
      .rsp_position (rsp_position),
      .rsp_length   (rsp_length),
      .rsp_empty    (rsp_empty)
   );

   // Pack the response item
   assign rsp_tdata = {6'b0, rsp_empty, rsp_length, rsp_position, rsp_value};

endmodule
